// ===== rtl/core/szt_pkg.sv =====
// Shared types and constants of the symmetric Zobrist transposition table.
package szt_pkg;

    localparam logic [2:0] CMD_LOAD   = 3'd0;
    localparam logic [2:0] CMD_CLEAR  = 3'd1;
    localparam logic [2:0] CMD_TOGGLE = 3'd2;
    localparam logic [2:0] CMD_STORE  = 3'd3;
    localparam logic [2:0] CMD_LOOKUP = 3'd4;

    localparam logic [2:0] ADDR_ROWS = 3'd0;
    localparam logic [2:0] ADDR_COLS = 3'd4;

    localparam int ORIENTS = 4;
    localparam int CELL_W  = 7;
    localparam int DIM_W   = 5;
    localparam int ZADDR_W = 10;
    localparam int MASK_W  = 128;

    typedef struct packed {
        logic [31:0]       code;
        logic [MASK_W-1:0] mask;
    } okey_t;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic [31:0]       nodes;
        logic [7:0]        depth;
        logic [31:0]       value;
    } slot_t;

    typedef struct packed {
        logic               valid;
        logic [2:0]         cmd;
        logic [CELL_W-1:0]  cell_idx;
        logic [ZADDR_W-1:0] zaddr;
        logic [31:0]        zword;
    } key_req_t;

    typedef struct packed {
        logic        valid;
        logic        is_store;
        logic [7:0]  depth;
        logic [31:0] nodes;
        logic [31:0] value;
    } tbl_req_t;

    typedef struct packed {
        logic        done;
        logic        hit;
        logic [31:0] value;
    } tbl_rsp_t;

endpackage

// ===== rtl/core/szt_div.sv =====
// Iterative restoring divider of a cell index by a board dimension.
module szt_div
    import szt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [CELL_W-1:0] dividend,
    input  logic [DIM_W-1:0]  divisor,
    output logic              done,
    output logic [CELL_W-1:0] quot,
    output logic [DIM_W-1:0]  rem
);

    logic [CELL_W-1:0] quo_reg, quo_next;
    logic [DIM_W-1:0]  rem_reg, rem_next;
    logic [DIM_W-1:0]  dvs_reg, dvs_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIM_W:0]    trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[CELL_W-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 3'(CELL_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // One quotient bit per cycle.
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DIM_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[CELL_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIM_W-1:0];
                quo_next = {quo_reg[CELL_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 3'd1;
            if (cnt_reg == 3'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/core/szt_keys.sv =====
// Zobrist word memory and the four orientation keys with their toggle sequencer.
module szt_keys
    import szt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  key_req_t                  req,
    input  logic [DIM_W-1:0]          rows,
    input  logic [DIM_W-1:0]          cols,
    output okey_t [ORIENTS-1:0]       keys,
    output logic                      done
);

    localparam logic [1:0] K_IDLE = 2'd0;
    localparam logic [1:0] K_DIV0 = 2'd1;
    localparam logic [1:0] K_DIVK = 2'd2;
    localparam logic [1:0] K_XOR  = 2'd3;

    logic [1:0]               state_reg, state_next;
    okey_t [ORIENTS-1:0]      keys_reg, keys_next;
    logic [CELL_W-1:0]        cell_reg, cell_next;
    logic [CELL_W-1:0]        r_reg, r_next;
    logic [DIM_W-1:0]         c_reg, c_next;
    logic [CELL_W-1:0]        m_reg, m_next;
    logic [1:0]               k_reg, k_next;
    logic                     done_reg, done_next;

    logic                     div_start;
    logic [CELL_W-1:0]        div_dvd;
    logic                     div_done;
    logic [CELL_W-1:0]        div_q;
    logic [DIM_W-1:0]         div_r;

    logic [31:0]              zmem [0:(1 << ZADDR_W)-1];
    logic [31:0]              zdata_reg;
    logic                     zrd;
    logic [ZADDR_W-1:0]       zrd_addr;
    logic [DIM_W-1:0]         qlow;

    logic [1:0]               k_nxt;
    logic [DIM_W-1:0]         cc;
    logic [CELL_W-1:0]        rr;
    logic [CELL_W-1:0]        row_sel;
    logic [DIM_W-1:0]         col_sel;
    logic [CELL_W+DIM_W-1:0]  prod;
    logic [CELL_W-1:0]        m_mir;

    szt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (cols),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    // Mirrored cell of the next orientation, wrapped to the 128-cell range.
    always_comb
    begin
        k_nxt = k_reg + 2'd1;
        cc    = cols - c_reg - DIM_W'(1);
        rr    = CELL_W'(rows) - r_reg - CELL_W'(1);
        case (k_nxt)
            2'd1:    begin row_sel = r_reg; col_sel = cc;    end
            2'd2:    begin row_sel = rr;    col_sel = c_reg; end
            2'd3:    begin row_sel = rr;    col_sel = cc;    end
            default: begin row_sel = r_reg; col_sel = c_reg; end
        endcase
        prod  = row_sel * cols;
        m_mir = prod[CELL_W-1:0] + CELL_W'(col_sel);
    end

    always_comb
    begin
        qlow     = DIM_W'(div_q) + DIM_W'(1);
        zrd_addr = {qlow, 5'd0} + ZADDR_W'(div_r) + ZADDR_W'(1);
    end

    always_comb
    begin
        state_next = state_reg;
        keys_next  = keys_reg;
        cell_next  = cell_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        m_next     = m_reg;
        k_next     = k_reg;
        done_next  = 1'b0;
        div_start  = 1'b0;
        div_dvd    = cell_reg;
        zrd        = 1'b0;
        unique case (state_reg)
            K_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.cmd)
                        CMD_CLEAR:
                        begin
                            keys_next = '0;
                            done_next = 1'b1;
                        end
                        CMD_TOGGLE:
                        begin
                            cell_next  = req.cell_idx;
                            div_dvd    = req.cell_idx;
                            div_start  = 1'b1;
                            state_next = K_DIV0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            K_DIV0:
            begin
                if (div_done)
                begin
                    r_next     = div_q;
                    c_next     = div_r;
                    k_next     = 2'd0;
                    m_next     = cell_reg;
                    div_dvd    = cell_reg;
                    div_start  = 1'b1;
                    state_next = K_DIVK;
                end
            end
            K_DIVK:
            begin
                if (div_done)
                begin
                    zrd        = 1'b1;
                    state_next = K_XOR;
                end
            end
            K_XOR:
            begin
                keys_next[k_reg].code = keys_reg[k_reg].code ^ zdata_reg;
                keys_next[k_reg].mask = keys_reg[k_reg].mask ^ (MASK_W'(1) << m_reg);
                if (k_reg == 2'(ORIENTS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = K_IDLE;
                end
                else
                begin
                    k_next     = k_nxt;
                    m_next     = m_mir;
                    div_dvd    = m_mir;
                    div_start  = 1'b1;
                    state_next = K_DIVK;
                end
            end
            default:
            begin
                state_next = K_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= K_IDLE;
            keys_reg  <= '0;
            k_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            keys_reg  <= keys_next;
            k_reg     <= k_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
        r_reg    <= r_next;
        c_reg    <= c_next;
        m_reg    <= m_next;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && state_reg == K_IDLE && req.cmd == CMD_LOAD)
        begin
            zmem[req.zaddr] <= req.zword;
        end
        if (zrd)
        begin
            zdata_reg <= zmem[zrd_addr];
        end
    end

    assign keys = keys_reg;
    assign done = done_reg;

endmodule

// ===== rtl/core/szt_table.sv =====
// Slot memory with its clearing pass and the store and lookup probe sequencer.
module szt_table
    import szt_pkg::*;
#(
    parameter int TABLE_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tbl_req_t             req,
    input  okey_t [ORIENTS-1:0]  keys,
    output logic                 ready,
    output tbl_rsp_t             rsp
);

    localparam logic [1:0] T_CLR  = 2'd0;
    localparam logic [1:0] T_IDLE = 2'd1;
    localparam logic [1:0] T_EVAL = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [TABLE_BITS-1:0] clr_reg, clr_next;
    logic [1:0]            k_reg, k_next;
    logic                  store_reg, store_next;
    logic [7:0]            depth_reg, depth_next;
    logic [31:0]           nodes_reg, nodes_next;
    logic [31:0]           value_reg, value_next;
    tbl_rsp_t              rsp_reg, rsp_next;

    slot_t                 smem [0:(1 << TABLE_BITS)-1];
    slot_t                 rd_reg;
    logic                  rd_en;
    logic [TABLE_BITS-1:0] rd_addr;
    logic                  wr_en;
    logic [TABLE_BITS-1:0] wr_addr;
    slot_t                 wr_data;
    logic [1:0]            k_nxt;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        k_next     = k_reg;
        store_next = store_reg;
        depth_next = depth_reg;
        nodes_next = nodes_reg;
        value_next = value_reg;
        rsp_next   = '0;
        rd_en      = 1'b0;
        rd_addr    = keys[0].code[TABLE_BITS-1:0];
        wr_en      = 1'b0;
        wr_addr    = keys[k_reg].code[TABLE_BITS-1:0];
        wr_data    = '0;
        k_nxt      = k_reg + 2'd1;
        unique case (state_reg)
            T_CLR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + TABLE_BITS'(1);
                if (clr_reg == {TABLE_BITS{1'b1}})
                begin
                    state_next = T_IDLE;
                end
            end
            T_IDLE:
            begin
                if (req.valid)
                begin
                    store_next = req.is_store;
                    depth_next = req.depth;
                    nodes_next = req.nodes;
                    value_next = req.value;
                    k_next     = 2'd0;
                    rd_en      = 1'b1;
                    state_next = T_EVAL;
                end
            end
            T_EVAL:
            begin
                if (store_reg && rd_reg.nodes <= nodes_reg)
                begin
                    wr_en         = 1'b1;
                    wr_data.mask  = keys[k_reg].mask;
                    wr_data.nodes = nodes_reg;
                    wr_data.depth = depth_reg;
                    wr_data.value = value_reg;
                    rsp_next.done = 1'b1;
                    state_next    = T_IDLE;
                end
                else if (!store_reg && rd_reg.mask == keys[k_reg].mask
                         && rd_reg.depth >= depth_reg)
                begin
                    rsp_next.done  = 1'b1;
                    rsp_next.hit   = 1'b1;
                    rsp_next.value = rd_reg.value;
                    state_next     = T_IDLE;
                end
                else if (k_reg == 2'(ORIENTS - 1))
                begin
                    rsp_next.done = 1'b1;
                    state_next    = T_IDLE;
                end
                else
                begin
                    k_next  = k_nxt;
                    rd_en   = 1'b1;
                    rd_addr = keys[k_nxt].code[TABLE_BITS-1:0];
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_CLR;
            clr_reg   <= '0;
            k_reg     <= '0;
            rsp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            k_reg     <= k_next;
            rsp_reg   <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
        depth_reg <= depth_next;
        nodes_reg <= nodes_next;
        value_reg <= value_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            smem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= smem[rd_addr];
        end
    end

    assign ready = (state_reg == T_IDLE);
    assign rsp   = rsp_reg;

    // A request is only ever issued once the clearing pass is over.
    a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |-> state_reg == T_IDLE)
        else $error("table request during clearing pass");

endmodule

// ===== rtl/core/symmetric_zobrist_transposition_table.sv =====
// Top level of the symmetric Zobrist transposition table.
//
// Commands arrive on a valid/ready input channel (cmd with its operand fields) and each
// transaction yields exactly one result transaction (hit, found_value) on a valid/ready
// output channel; only a lookup can report a hit. The board size is set through an
// APB-style port: row_count at address 0, col_count at address 4, a zero taken as one.
// Write them only while the block is idle.
// Load and clear keys report back from the key unit, while an unknown code goes straight
// to the result. Store and lookup make one slot memory read per probed orientation.
// A toggle runs one division of the cell index and then, per orientation, another division
// plus a Zobrist memory read; all divisions use the one shared iterative divider.
// One command is worked on at a time, but the next is accepted while a finished result
// still waits in the output register.
// After reset the orientation keys are zero and the slot memory is swept to zero, one
// entry per cycle, over all 2**TABLE_BITS entries, during which in_ready stays low;
// configuration writes are still taken. The Zobrist words hold nothing until loaded.
// When the receiver stalls, the result is held in the output register and a finished
// command waits for it to drain before posting its own result.
module symmetric_zobrist_transposition_table
    import szt_pkg::*;
#(
    parameter int TABLE_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         cmd,
    input  logic [6:0]         cell_index,
    input  logic [7:0]         search_depth,
    input  logic [31:0]        subtree_nodes,
    input  logic signed [31:0] entry_value,
    input  logic [9:0]         zobrist_index,
    input  logic [31:0]        zobrist_word,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic signed [31:0] found_value
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [DIM_W-1:0]    row_reg, row_next;
    logic [DIM_W-1:0]    col_reg, col_next;
    logic                out_valid_reg, out_valid_next;
    logic                hit_reg, hit_next;
    logic [31:0]         val_reg, val_next;
    logic                res_hit_reg, res_hit_next;
    logic [31:0]         res_val_reg, res_val_next;

    logic                in_acc;
    logic                cfg_wr;
    logic [DIM_W-1:0]    rows_eff;
    logic [DIM_W-1:0]    cols_eff;
    key_req_t            key_req;
    tbl_req_t            tbl_req;
    tbl_rsp_t            tbl_rsp;
    logic                tbl_ready;
    logic                keys_done;
    okey_t [ORIENTS-1:0] keys;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign prdata   = paddr[2] ? {27'd0, col_reg} : {27'd0, row_reg};
    assign rows_eff = (row_reg == '0) ? DIM_W'(1) : row_reg;
    assign cols_eff = (col_reg == '0) ? DIM_W'(1) : col_reg;

    assign in_ready = (state_reg == ST_IDLE) && tbl_ready;
    assign in_acc   = in_valid && in_ready;

    // Commands that touch only the keys go to the key unit, probes to the table.
    always_comb
    begin
        key_req.valid    = in_acc && (cmd == CMD_LOAD || cmd == CMD_CLEAR
                                      || cmd == CMD_TOGGLE);
        key_req.cmd      = cmd;
        key_req.cell_idx = cell_index;
        key_req.zaddr    = zobrist_index;
        key_req.zword    = zobrist_word;
        tbl_req.valid    = in_acc && (cmd == CMD_STORE || cmd == CMD_LOOKUP);
        tbl_req.is_store = (cmd == CMD_STORE);
        tbl_req.depth    = search_depth;
        tbl_req.nodes    = subtree_nodes;
        tbl_req.value    = entry_value;
    end

    szt_keys u_keys (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (key_req),
        .rows  (rows_eff),
        .cols  (cols_eff),
        .keys  (keys),
        .done  (keys_done)
    );

    szt_table #(
        .TABLE_BITS (TABLE_BITS)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tbl_req),
        .keys  (keys),
        .ready (tbl_ready),
        .rsp   (tbl_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg;
        hit_next       = hit_reg;
        val_next       = val_reg;
        res_hit_next   = res_hit_reg;
        res_val_next   = res_val_reg;

        if (cfg_wr)
        begin
            if (paddr[2])
            begin
                col_next = pwdata[DIM_W-1:0];
            end
            else
            begin
                row_next = pwdata[DIM_W-1:0];
            end
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    res_hit_next = 1'b0;
                    res_val_next = '0;
                    if (key_req.valid || tbl_req.valid)
                    begin
                        state_next = ST_BUSY;
                    end
                    else
                    begin
                        // Unknown command codes change nothing.
                        state_next = ST_FIN;
                    end
                end
            end
            ST_BUSY:
            begin
                if (tbl_rsp.done)
                begin
                    res_hit_next = tbl_rsp.hit;
                    res_val_next = tbl_rsp.value;
                    state_next   = ST_FIN;
                end
                else if (keys_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = res_hit_reg;
                    val_next       = res_val_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= DIM_W'(8);
            col_reg       <= DIM_W'(8);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg     <= hit_next;
        val_reg     <= val_next;
        res_hit_reg <= res_hit_next;
        res_val_reg <= res_val_next;
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign found_value = val_reg;

    a_one_unit_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(keys_done && tbl_rsp.done))
        else $error("key unit and table finished in the same cycle");

    a_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (keys_done || tbl_rsp.done) |-> state_reg == ST_BUSY)
        else $error("unit finished with no transaction in progress");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg != ST_IDLE)
        else $error("accepted transaction left the controller idle");

endmodule
